/* sv/gpd_pkg.sv */
// shared types and constants of the gaze presence dwell tracker
package gpd_pkg;

  localparam int unsigned TIME_BITS = 40;
  localparam int unsigned STAMP_W   = 40;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned CERT_W    = 7;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned DWELL_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MAX_EVT   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DWELL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_DWELL = 2'd3;

  // register reset values
  localparam logic [LIMIT_W-1:0] YAW_LIMIT_RST   = 15'd1500;
  localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RST = 15'd1500;
  localparam logic [DWELL_W-1:0] ENTER_DWELL_RST = 16'd300;
  localparam logic [DWELL_W-1:0] LEAVE_DWELL_RST = 16'd800;

  // input operation codes
  localparam logic OP_OBSERVE   = 1'b0;
  localparam logic OP_FACE_LOST = 1'b1;

  typedef enum logic [2:0] {
    KIND_PRESENCE_ENTER = 3'd0,
    KIND_GAZE_ENTER     = 3'd1,
    KIND_GAZE_LEAVE     = 3'd2,
    KIND_POSE           = 3'd3,
    KIND_PRESENCE_LEAVE = 3'd4
  } gpd_kind_e;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] yaw_limit;
    logic [LIMIT_W-1:0] pitch_limit;
    logic [DWELL_W-1:0] enter_dwell;
    logic [DWELL_W-1:0] leave_dwell;
  } gpd_cfg_t;

  typedef struct packed {
    logic  face_seen;
    logic  gaze_on;
    time_t enter_start;
    time_t leave_start;
  } gpd_state_t;

  // events an item produces, in order, and how many
  typedef struct packed {
    gpd_kind_e [MAX_EVT-1:0] kinds;
    logic [1:0]              count;
  } gpd_plan_t;

  typedef struct packed {
    logic                       op;
    logic [STAMP_W-1:0]         stamp_ms;
    logic [COORD_W-1:0]         face_x;
    logic [COORD_W-1:0]         face_y;
    logic [COORD_W-1:0]         face_w;
    logic [COORD_W-1:0]         face_h;
    logic signed [ANGLE_W-1:0]  yaw_cdeg;
    logic signed [ANGLE_W-1:0]  pitch_cdeg;
    logic signed [ANGLE_W-1:0]  roll_cdeg;
    logic [CERT_W-1:0]          certainty;
  } gpd_item_t;

endpackage

/* sv/gpd_if.sv */
// channel interfaces: observation items, result events and register writes

interface gpd_item_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [gpd_pkg::STAMP_W-1:0]        stamp_ms;
  logic [gpd_pkg::COORD_W-1:0]        face_x;
  logic [gpd_pkg::COORD_W-1:0]        face_y;
  logic [gpd_pkg::COORD_W-1:0]        face_w;
  logic [gpd_pkg::COORD_W-1:0]        face_h;
  logic signed [gpd_pkg::ANGLE_W-1:0] yaw_cdeg;
  logic signed [gpd_pkg::ANGLE_W-1:0] pitch_cdeg;
  logic signed [gpd_pkg::ANGLE_W-1:0] roll_cdeg;
  logic [gpd_pkg::CERT_W-1:0]         certainty;

  modport source (
    output valid, op, stamp_ms, face_x, face_y, face_w, face_h,
           yaw_cdeg, pitch_cdeg, roll_cdeg, certainty,
    input  ready
  );
  modport sink (
    input  valid, op, stamp_ms, face_x, face_y, face_w, face_h,
           yaw_cdeg, pitch_cdeg, roll_cdeg, certainty,
    output ready
  );
endinterface

interface gpd_event_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         event_kind;
  logic [gpd_pkg::STAMP_W-1:0]        event_ms;
  logic [gpd_pkg::COORD_W-1:0]        pose_x;
  logic [gpd_pkg::COORD_W-1:0]        pose_y;
  logic [gpd_pkg::COORD_W-1:0]        pose_w;
  logic [gpd_pkg::COORD_W-1:0]        pose_h;
  logic signed [gpd_pkg::ANGLE_W-1:0] pose_yaw;
  logic signed [gpd_pkg::ANGLE_W-1:0] pose_pitch;
  logic signed [gpd_pkg::ANGLE_W-1:0] pose_roll;
  logic [gpd_pkg::CERT_W-1:0]         event_certainty;
  logic                               last;

  modport source (
    output valid, event_kind, event_ms, pose_x, pose_y, pose_w, pose_h,
           pose_yaw, pose_pitch, pose_roll, event_certainty, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_ms, pose_x, pose_y, pose_w, pose_h,
           pose_yaw, pose_pitch, pose_roll, event_certainty, last,
    output ready
  );
endinterface

interface gpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gpd_pkg::CFG_IDX_W-1:0] index;
  logic [gpd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/gpd_step.sv */
// per-item decision logic: presence, facing test, dwell timing and event list
module gpd_step (
  input  logic                               op_i,
  input  logic [gpd_pkg::STAMP_W-1:0]        stamp_ms_i,
  input  logic signed [gpd_pkg::ANGLE_W-1:0] yaw_i,
  input  logic signed [gpd_pkg::ANGLE_W-1:0] pitch_i,
  input  gpd_pkg::gpd_cfg_t                  cfg_i,
  input  gpd_pkg::gpd_state_t                state_i,
  output gpd_pkg::gpd_state_t                state_o,
  output gpd_pkg::gpd_plan_t                 plan_o
);

  logic [gpd_pkg::ANGLE_W:0] yaw_ext, pitch_ext, yaw_mag, pitch_mag;
  gpd_pkg::time_t            now;
  gpd_pkg::time_t            enter_eff, leave_eff;
  gpd_pkg::time_t            enter_age, leave_age;
  logic                      facing, enter_done, leave_done;

  assign yaw_ext   = {yaw_i[gpd_pkg::ANGLE_W-1], yaw_i};
  assign pitch_ext = {pitch_i[gpd_pkg::ANGLE_W-1], pitch_i};
  assign yaw_mag   = yaw_i[gpd_pkg::ANGLE_W-1] ? ((gpd_pkg::ANGLE_W+1)'(0) - yaw_ext) : yaw_ext;
  assign pitch_mag = pitch_i[gpd_pkg::ANGLE_W-1] ? ((gpd_pkg::ANGLE_W+1)'(0) - pitch_ext)
                                                  : pitch_ext;

  assign facing = (yaw_mag <= (gpd_pkg::ANGLE_W+1)'(cfg_i.yaw_limit)) &&
                  (pitch_mag <= (gpd_pkg::ANGLE_W+1)'(cfg_i.pitch_limit));

  assign now = gpd_pkg::time_t'(stamp_ms_i);

  // a start time of zero means no candidate yet, so it starts now
  assign enter_eff = (state_i.enter_start == '0) ? now : state_i.enter_start;
  assign leave_eff = (state_i.leave_start == '0) ? now : state_i.leave_start;
  assign enter_age = now - enter_eff;
  assign leave_age = now - leave_eff;

  // time running backwards counts as not yet elapsed
  assign enter_done = (now >= enter_eff) && (enter_age >= gpd_pkg::time_t'(cfg_i.enter_dwell));
  assign leave_done = (now >= leave_eff) && (leave_age >= gpd_pkg::time_t'(cfg_i.leave_dwell));

  always_comb begin
    logic [1:0] n;
    n       = 2'd0;
    state_o = state_i;
    for (int unsigned k = 0; k < gpd_pkg::MAX_EVT; k++) begin
      plan_o.kinds[k] = gpd_pkg::KIND_POSE;
    end
    if (op_i == gpd_pkg::OP_FACE_LOST) begin
      if (state_i.face_seen || state_i.gaze_on) begin
        plan_o.kinds[0] = gpd_pkg::KIND_PRESENCE_LEAVE;
        n = 2'd1;
        state_o = '0;
      end
    end else begin
      if (!state_i.face_seen) begin
        plan_o.kinds[n] = gpd_pkg::KIND_PRESENCE_ENTER;
        n = n + 2'd1;
        state_o.face_seen = 1'b1;
      end
      if (facing) begin
        state_o.leave_start = '0;
        if (!state_i.gaze_on) begin
          if (enter_done) begin
            plan_o.kinds[n] = gpd_pkg::KIND_GAZE_ENTER;
            n = n + 2'd1;
            state_o.gaze_on = 1'b1;
            state_o.enter_start = '0;
          end else begin
            state_o.enter_start = enter_eff;
          end
        end
      end else begin
        state_o.enter_start = '0;
        if (state_i.gaze_on) begin
          if (leave_done) begin
            plan_o.kinds[n] = gpd_pkg::KIND_GAZE_LEAVE;
            n = n + 2'd1;
            state_o.gaze_on = 1'b0;
            state_o.leave_start = '0;
          end else begin
            state_o.leave_start = leave_eff;
          end
        end
      end
      plan_o.kinds[n] = gpd_pkg::KIND_POSE;
      n = n + 2'd1;
    end
    plan_o.count = n;
  end

endmodule

/* sv/gaze_presence_dwell_tracker.sv */
// top level of the gaze presence dwell tracker
//
// in_i carries timestamped face observations and face-lost events; out_o
// carries the resulting events, presence enter, gaze enter, gaze leave,
// pose and presence leave, with last marking the final event of an item.
// cfg_i writes the four registers (yaw and pitch limits, enter and leave
// dwell times); it is always ready and is meant to be used while idle.
//
// an item is held in an input register, then it is evaluated combinationally
// against the tracking state and its event list is loaded into the result
// register once that is free. the first event is valid once the list is loaded.
// a face-lost item produces at most one event and an observation up to
// three; the single result register hands the events out one per cycle
// while the receiver is ready. an item that produces nothing (face lost
// with nothing present) passes through and leaves the result register empty.
// the input register takes the next item while events still wait.
//
// reset clears the tracking state, empties both registers and returns the
// configuration registers to their defaults. if the receiver stalls, the
// current event holds, then the input register fills and in_i.ready drops.
module gaze_presence_dwell_tracker (
  input  logic   clk_i,
  input  logic   rst_ni,
  gpd_item_if.sink    in_i,
  gpd_event_if.source out_o,
  gpd_cfg_if.sink     cfg_i
);

  // configuration registers
  gpd_pkg::gpd_cfg_t cfg_q;

  // input register
  logic              in_vld_q;
  gpd_pkg::gpd_item_t in_q;

  // tracking state
  gpd_pkg::gpd_state_t state_q, state_d;
  gpd_pkg::gpd_plan_t  plan;

  // result register: shared payload plus the pending event list
  gpd_pkg::gpd_item_t               res_q;
  gpd_pkg::gpd_kind_e [gpd_pkg::MAX_EVT-1:0] kinds_q;
  logic [1:0]                       rem_q;   // events still to transfer
  logic [1:0]                       idx_q;   // slot of the current event

  logic in_xfer, out_xfer, res_free, load;
  gpd_pkg::gpd_kind_e kind;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yaw_limit   <= gpd_pkg::YAW_LIMIT_RST;
      cfg_q.pitch_limit <= gpd_pkg::PITCH_LIMIT_RST;
      cfg_q.enter_dwell <= gpd_pkg::ENTER_DWELL_RST;
      cfg_q.leave_dwell <= gpd_pkg::LEAVE_DWELL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gpd_pkg::CFG_YAW_LIMIT:   cfg_q.yaw_limit   <= cfg_i.data[gpd_pkg::LIMIT_W-1:0];
        gpd_pkg::CFG_PITCH_LIMIT: cfg_q.pitch_limit <= cfg_i.data[gpd_pkg::LIMIT_W-1:0];
        gpd_pkg::CFG_ENTER_DWELL: cfg_q.enter_dwell <= cfg_i.data[gpd_pkg::DWELL_W-1:0];
        gpd_pkg::CFG_LEAVE_DWELL: cfg_q.leave_dwell <= cfg_i.data[gpd_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes: the result register frees up as its last event transfers
  assign out_xfer   = out_o.valid && out_o.ready;
  assign res_free   = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_o.ready);
  assign load       = in_vld_q && res_free;
  assign in_i.ready = !in_vld_q || load;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.op         <= in_i.op;
      in_q.stamp_ms   <= in_i.stamp_ms;
      in_q.face_x     <= in_i.face_x;
      in_q.face_y     <= in_i.face_y;
      in_q.face_w     <= in_i.face_w;
      in_q.face_h     <= in_i.face_h;
      in_q.yaw_cdeg   <= in_i.yaw_cdeg;
      in_q.pitch_cdeg <= in_i.pitch_cdeg;
      in_q.roll_cdeg  <= in_i.roll_cdeg;
      in_q.certainty  <= in_i.certainty;
    end
  end

  // item evaluation
  gpd_step u_step (
    .op_i       (in_q.op),
    .stamp_ms_i (in_q.stamp_ms),
    .yaw_i      (in_q.yaw_cdeg),
    .pitch_i    (in_q.pitch_cdeg),
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .plan_o     (plan)
  );

  // state advances exactly once per item, when it moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load) begin
      rem_q <= plan.count;
      idx_q <= 2'd0;
    end else if (out_xfer) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q   <= in_q;
      kinds_q <= plan.kinds;
    end
  end

  // output view of the current event
  assign kind = kinds_q[idx_q];

  assign out_o.valid           = (rem_q != 2'd0);
  assign out_o.last            = (rem_q == 2'd1);
  assign out_o.event_kind      = 3'(kind);
  assign out_o.event_ms        = res_q.stamp_ms;
  assign out_o.event_certainty = (kind == gpd_pkg::KIND_PRESENCE_LEAVE) ? '0 : res_q.certainty;
  assign out_o.pose_x          = (kind == gpd_pkg::KIND_POSE) ? res_q.face_x     : '0;
  assign out_o.pose_y          = (kind == gpd_pkg::KIND_POSE) ? res_q.face_y     : '0;
  assign out_o.pose_w          = (kind == gpd_pkg::KIND_POSE) ? res_q.face_w     : '0;
  assign out_o.pose_h          = (kind == gpd_pkg::KIND_POSE) ? res_q.face_h     : '0;
  assign out_o.pose_yaw        = (kind == gpd_pkg::KIND_POSE) ? res_q.yaw_cdeg   : '0;
  assign out_o.pose_pitch      = (kind == gpd_pkg::KIND_POSE) ? res_q.pitch_cdeg : '0;
  assign out_o.pose_roll       = (kind == gpd_pkg::KIND_POSE) ? res_q.roll_cdeg  : '0;

endmodule

/* sv/gpd_checker.sv */
// port-level checks of the tracker's event stream, bound to the top level
module gpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [2:0]                  out_kind_i,
  input logic [gpd_pkg::STAMP_W-1:0] out_ms_i,
  input logic [gpd_pkg::COORD_W-1:0] out_x_i,
  input logic [gpd_pkg::ANGLE_W-1:0] out_yaw_i,
  input logic                        out_last_i
);

  // a stalled event keeps its kind and time
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_ms_i))
    else $error("stalled event changed");

  // pose and presence leave close an item, and only they do
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == ((out_kind_i == 3'(gpd_pkg::KIND_POSE)) ||
                                    (out_kind_i == 3'(gpd_pkg::KIND_PRESENCE_LEAVE)))))
    else $error("last flag does not match event kind");

  // events of one item follow back to back with the same time
  a_same_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_ms_i == $past(out_ms_i))
    else $error("event of an item missing or with another time");

  // pose fields are zero outside pose events
  a_pose_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != 3'(gpd_pkg::KIND_POSE)) |-> out_x_i == '0 && out_yaw_i == '0)
    else $error("pose fields set on a non-pose event");

endmodule

bind gaze_presence_dwell_tracker gpd_checker u_gpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.event_kind),
  .out_ms_i    (out_o.event_ms),
  .out_x_i     (out_o.pose_x),
  .out_yaw_i   (out_o.pose_yaw),
  .out_last_i  (out_o.last)
);

/* dv/tb_gaze_presence_dwell_tracker.sv */
// testbench for the gaze presence dwell tracker: directed and random items against a local model
`timescale 1ns / 1ps

module tb_gaze_presence_dwell_tracker;
  import gpd_pkg::*;

  // one result event as the block should hand it out
  typedef struct {
    gpd_kind_e                 kind;
    time_t                     ms;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic [CERT_W-1:0]         cert;
    logic                      last;
  } tracker_event_t;

  // how the result side paces its ready
  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_CADENCE,
    SINK_CHOKED
  } sink_mode_e;

  // cycles to let pass once nothing is due, covers an item that yields no event
  localparam int IDLE_MARGIN = 6;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_CAP   = 30;
  localparam int ANGLE_MAG   = 32768;

  logic clk_i = 1'b0;
  logic rst_ni;

  gpd_item_if  item_ch ();
  gpd_event_if event_ch ();
  gpd_cfg_if   cfg_ch ();

  gaze_presence_dwell_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (event_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the registers and tracking state
  gpd_cfg_t   shadow_cfg  = {YAW_LIMIT_RST, PITCH_LIMIT_RST, ENTER_DWELL_RST, LEAVE_DWELL_RST};
  gpd_state_t track_state = '0;

  // events predicted but not yet seen on the result channel, oldest first
  tracker_event_t due_events[$];

  int         err_count   = 0;
  sink_mode_e sink_mode   = SINK_OPEN;
  int         gap_max     = 0;
  int         burst_left  = 0;
  int         hold_req_id = 0;
  int         hold_req_len = 0;

  task automatic report(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [16:0] abs_cdeg(input logic [ANGLE_W-1:0] raw);
    // two's complement magnitude, -32768 comes out as 32768
    return raw[ANGLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
  endfunction

  function automatic logic dwell_met(input time_t from, input time_t now,
                                     input logic [DWELL_W-1:0] dwell);
    // time running backwards counts as not yet elapsed
    return (now >= from) && ((now - from) >= time_t'(dwell));
  endfunction

  function automatic tracker_event_t event_for(input gpd_kind_e kind, input gpd_item_t it);
    tracker_event_t ev;
    ev.kind  = kind;
    ev.ms    = it.stamp_ms;
    ev.cert  = (kind == KIND_PRESENCE_LEAVE) ? '0 : it.certainty;
    ev.last  = (kind == KIND_POSE) || (kind == KIND_PRESENCE_LEAVE);
    // pose fields only travel with the pose event
    if (kind == KIND_POSE) begin
      ev.x     = it.face_x;
      ev.y     = it.face_y;
      ev.w     = it.face_w;
      ev.h     = it.face_h;
      ev.yaw   = it.yaw_cdeg;
      ev.pitch = it.pitch_cdeg;
      ev.roll  = it.roll_cdeg;
    end else begin
      ev.x     = '0;
      ev.y     = '0;
      ev.w     = '0;
      ev.h     = '0;
      ev.yaw   = '0;
      ev.pitch = '0;
      ev.roll  = '0;
    end
    return ev;
  endfunction

  // appends one predicted event at the young end of the queue
  task automatic queue_event(input tracker_event_t ev);
    due_events = {due_events, ev};
  endtask

  // advances the tracking state by one accepted item and queues its events
  task automatic track_item(input gpd_item_t it);
    logic facing;
    if (it.op == OP_FACE_LOST) begin
      // face lost with nothing present yields no event at all
      if (track_state.face_seen || track_state.gaze_on) begin
        queue_event(event_for(KIND_PRESENCE_LEAVE, it));
        track_state = '0;
      end
      return;
    end
    if (!track_state.face_seen) begin
      queue_event(event_for(KIND_PRESENCE_ENTER, it));
      track_state.face_seen = 1'b1;
    end
    facing = (abs_cdeg(it.yaw_cdeg) <= 17'(shadow_cfg.yaw_limit)) &&
             (abs_cdeg(it.pitch_cdeg) <= 17'(shadow_cfg.pitch_limit));
    // a start time of zero means no candidate, so a candidate born at zero restarts
    if (facing) begin
      track_state.leave_start = '0;
      if (!track_state.gaze_on) begin
        if (track_state.enter_start == '0) begin
          track_state.enter_start = it.stamp_ms;
        end
        if (dwell_met(track_state.enter_start, it.stamp_ms, shadow_cfg.enter_dwell)) begin
          queue_event(event_for(KIND_GAZE_ENTER, it));
          track_state.gaze_on     = 1'b1;
          track_state.enter_start = '0;
        end
      end
    end else begin
      track_state.enter_start = '0;
      if (track_state.gaze_on) begin
        if (track_state.leave_start == '0) begin
          track_state.leave_start = it.stamp_ms;
        end
        if (dwell_met(track_state.leave_start, it.stamp_ms, shadow_cfg.leave_dwell)) begin
          queue_event(event_for(KIND_GAZE_LEAVE, it));
          track_state.gaze_on     = 1'b0;
          track_state.leave_start = '0;
        end
      end
    end
    queue_event(event_for(KIND_POSE, it));
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pacing and checking
  // ---------------------------------------------------------------------------

  // ready pattern; a requested hold-off is counted down here, cycle by cycle
  initial begin
    int hold_left;
    int hold_done;
    int phase;
    hold_left = 0;
    hold_done = 0;
    phase = 0;
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_id != hold_done) begin
        hold_done = hold_req_id;
        hold_left = hold_req_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        event_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:    event_ch.ready <= 1'b1;
          SINK_RANDOM:  event_ch.ready <= ($urandom_range(0, 3) != 0);
          SINK_CADENCE: event_ch.ready <= ((phase % 7) < 4);
          default:      event_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      phase++;
    end
  end

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // every transfer on the result channel is matched with the oldest prediction
  always @(posedge clk_i) begin
    tracker_event_t want;
    if (rst_ni && event_ch.valid && event_ch.ready) begin
      if (due_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d", event_ch.event_kind));
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", event_ch.event_kind, want.kind);
        check_field("event_ms", event_ch.event_ms, want.ms);
        check_field("pose_x", event_ch.pose_x, want.x);
        check_field("pose_y", event_ch.pose_y, want.y);
        check_field("pose_w", event_ch.pose_w, want.w);
        check_field("pose_h", event_ch.pose_h, want.h);
        check_field("pose_yaw", event_ch.pose_yaw, want.yaw);
        check_field("pose_pitch", event_ch.pose_pitch, want.pitch);
        check_field("pose_roll", event_ch.pose_roll, want.roll);
        check_field("event_certainty", event_ch.event_certainty, want.cert);
        check_field("last", event_ch.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------

  function automatic time_t rand_stamp();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic signed [ANGLE_W-1:0] pick_angle(input int lo, input int hi);
    int m;
    m = $urandom_range(lo, hi);
    // a magnitude of 32768 only exists as the negative extreme
    if (m == ANGLE_MAG || $urandom_range(0, 1) == 1) begin
      return ANGLE_W'(-m);
    end
    return ANGLE_W'(m);
  endfunction

  // fully random item, every field over its whole bit range
  function automatic gpd_item_t rand_item();
    gpd_item_t it;
    it.op         = 1'($urandom);
    it.stamp_ms   = rand_stamp();
    it.face_x     = 16'($urandom);
    it.face_y     = 16'($urandom);
    it.face_w     = 16'($urandom);
    it.face_h     = 16'($urandom);
    it.yaw_cdeg   = 16'($urandom);
    it.pitch_cdeg = 16'($urandom);
    it.roll_cdeg  = 16'($urandom);
    it.certainty  = 7'($urandom);
    return it;
  endfunction

  function automatic gpd_item_t observation(input time_t stamp,
                                            input logic signed [ANGLE_W-1:0] yaw,
                                            input logic signed [ANGLE_W-1:0] pitch);
    gpd_item_t it;
    it            = rand_item();
    it.op         = OP_OBSERVE;
    it.stamp_ms   = stamp;
    it.yaw_cdeg   = yaw;
    it.pitch_cdeg = pitch;
    return it;
  endfunction

  function automatic gpd_item_t lost_item(input time_t stamp);
    gpd_item_t it;
    it          = rand_item();
    it.op       = OP_FACE_LOST;
    it.stamp_ms = stamp;
    return it;
  endfunction

  // observation that is facing or averted under the current limits
  function automatic gpd_item_t gaze_item(input time_t stamp, input logic facing);
    int ylim;
    int plim;
    ylim = shadow_cfg.yaw_limit;
    plim = shadow_cfg.pitch_limit;
    if (facing) begin
      return observation(stamp, pick_angle(0, ylim), pick_angle(0, plim));
    end
    if ($urandom_range(0, 1) == 1) begin
      return observation(stamp, pick_angle(ylim + 1, ANGLE_MAG), pick_angle(0, ANGLE_MAG));
    end
    return observation(stamp, pick_angle(0, ANGLE_MAG), pick_angle(plim + 1, ANGLE_MAG));
  endfunction

  // offers one item, waits for its transfer, then maybe opens a gap before the next burst
  task automatic send_item(input gpd_item_t it);
    int gap;
    item_ch.valid      <= 1'b1;
    item_ch.op         <= it.op;
    item_ch.stamp_ms   <= it.stamp_ms;
    item_ch.face_x     <= it.face_x;
    item_ch.face_y     <= it.face_y;
    item_ch.face_w     <= it.face_w;
    item_ch.face_h     <= it.face_h;
    item_ch.yaw_cdeg   <= it.yaw_cdeg;
    item_ch.pitch_cdeg <= it.pitch_cdeg;
    item_ch.roll_cdeg  <= it.roll_cdeg;
    item_ch.certainty  <= it.certainty;
    do @(posedge clk_i); while (!item_ch.ready);
    track_item(it);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, gap_max);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stops offering, waits until every predicted event is out, then idles for IDLE_MARGIN
  task automatic settle();
    int spin;
    item_ch.valid <= 1'b0;
    spin = 0;
    while (due_events.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    if (due_events.size() != 0) begin
      report($sformatf("%0d events never arrived", due_events.size()));
      due_events.delete();
    end
    repeat (IDLE_MARGIN) @(posedge clk_i);
  endtask

  // writes all four registers back to back, only once the block is idle
  task automatic set_config(input logic [CFG_DAT_W-1:0] yaw_lim,
                            input logic [CFG_DAT_W-1:0] pitch_lim,
                            input logic [CFG_DAT_W-1:0] enter_ms,
                            input logic [CFG_DAT_W-1:0] leave_ms);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_DAT_W-1:0] val[4];
    idx = '{CFG_YAW_LIMIT, CFG_PITCH_LIMIT, CFG_ENTER_DWELL, CFG_LEAVE_DWELL};
    val = '{yaw_lim, pitch_lim, enter_ms, leave_ms};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
      // limit registers drop the top data bit
      case (idx[i])
        CFG_YAW_LIMIT:   shadow_cfg.yaw_limit   = val[i][LIMIT_W-1:0];
        CFG_PITCH_LIMIT: shadow_cfg.pitch_limit = val[i][LIMIT_W-1:0];
        CFG_ENTER_DWELL: shadow_cfg.enter_dwell = val[i];
        CFG_LEAVE_DWELL: shadow_cfg.leave_dwell = val[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // well-formed face sessions with random content, plus noise, lost faces
  // and time jumping backwards
  task automatic run_sessions(input int count);
    time_t clock_ms;
    logic  facing;
    int    run_left;
    int    step_max;
    int    pick;
    step_max = ((shadow_cfg.enter_dwell > shadow_cfg.leave_dwell) ?
                shadow_cfg.enter_dwell : shadow_cfg.leave_dwell) / 3 + 20;
    case ($urandom_range(0, 2))
      0:       clock_ms = time_t'($urandom_range(0, 1000));
      1:       clock_ms = rand_stamp();
      default: clock_ms = '1 - time_t'($urandom_range(0, 4 * step_max));
    endcase
    run_left = 0;
    facing = 1'b0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(rand_item());
      end else if (pick < 14) begin
        send_item(lost_item(clock_ms));
      end else begin
        // facing comes in runs so that dwell times can actually elapse
        if (run_left == 0) begin
          facing = 1'($urandom_range(0, 1));
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        if (pick < 19) begin
          clock_ms = clock_ms - time_t'($urandom_range(1, 200));
        end else begin
          clock_ms = clock_ms + time_t'($urandom_range(0, step_max));
        end
        send_item(gaze_item(clock_ms, facing));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: dwell thresholds, zero timestamps, backwards time, extremes
  task automatic test_directed();
    gpd_item_t it;
    sink_mode = SINK_RANDOM;
    gap_max = 2;
    send_item(lost_item(40'd1234));                   // nothing present, no event
    send_item(observation(40'd0, 16'sd0, 16'sd0));    // presence enter, candidate at zero
    send_item(observation(40'd100, 16'sd10, -16'sd10)); // candidate restarts at 100
    send_item(observation(40'd50, 16'sd0, 16'sd0));   // backwards, not elapsed
    send_item(observation(40'd399, 16'sd0, 16'sd0));  // one short of the dwell
    send_item(observation(40'd400, 16'sd0, 16'sd0));  // gaze enter
    send_item(observation(40'd500, 16'sh8000, 16'sd0)); // most negative yaw is averted
    send_item(observation(40'd600, 16'sd1500, -16'sd1500)); // limits exactly, facing
    send_item(observation(40'd700, 16'sd0, 16'sd1501));
    send_item(observation(40'd1500, -16'sd1501, 16'sd0)); // gaze leave
    it = observation(40'd1600, -16'sd1500, 16'sd1500);
    it.face_x = '1;
    it.face_y = '1;
    it.face_w = '1;
    it.face_h = '1;
    it.roll_cdeg = 16'sh7FFF;
    it.certainty = '1;                                // above 100, passed through
    send_item(it);
    send_item(lost_item(40'd1700));                   // presence leave
    send_item(lost_item(40'd1800));                   // already clear
    it = observation('1, 16'sd0, 16'sd0);
    it.face_x = '0;
    it.face_y = '0;
    it.face_w = '0;
    it.face_h = '0;
    it.roll_cdeg = 16'sh8000;
    it.certainty = '0;
    send_item(it);
    send_item(observation(40'd5, 16'sd0, 16'sd0));    // wrapped time, not elapsed
    send_item(lost_item(40'd6));
  endtask

  // zero and full-scale registers, including the dropped top bit of the limits
  task automatic test_register_extremes();
    sink_mode = SINK_CADENCE;
    gap_max = 0;
    set_config('0, '0, '0, '0);
    send_item(observation(40'd10, 16'sd0, 16'sd0));   // three events from one item
    send_item(observation(40'd20, 16'sd1, 16'sd0));   // instant gaze leave
    send_item(observation(40'd0, 16'sd0, 16'sd0));    // instant gaze enter at time zero
    send_item(lost_item(40'd30));
    set_config('1, '1, '1, '1);
    send_item(observation(40'd5, 16'sd32767, -16'sd32767));
    send_item(observation(40'd65540, 16'sd0, -16'sd32767)); // full dwell reached
    send_item(observation(40'd70000, 16'sh8000, 16'sd0));
    send_item(observation(40'd135534, 16'sd0, 16'sh8000)); // one short of leaving
    send_item(lost_item(40'd140000));
    // top data bit ignored: yaw limit reads as 100
    set_config(16'h8064, 16'h8064, '0, '0);
    send_item(observation(40'd200, 16'sd100, -16'sd100));
    send_item(observation(40'd201, 16'sd101, 16'sd0));
    send_item(lost_item(40'd202));
  endtask

  // result side held off for a long stretch while items keep coming
  task automatic test_backpressure();
    set_config(16'(YAW_LIMIT_RST), 16'(PITCH_LIMIT_RST), ENTER_DWELL_RST, LEAVE_DWELL_RST);
    sink_mode = SINK_OPEN;
    gap_max = 0;
    hold_req_len = 300;
    hold_req_id++;
    run_sessions(24);
  endtask

  // random sessions over several register settings and pacing styles
  task automatic test_random_sessions();
    set_config(16'(YAW_LIMIT_RST), 16'(PITCH_LIMIT_RST), ENTER_DWELL_RST, LEAVE_DWELL_RST);
    sink_mode = SINK_RANDOM;
    gap_max = 3;
    run_sessions(54);
    set_config(16'd200, 16'd200, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
    sink_mode = SINK_CADENCE;
    gap_max = 0;
    run_sessions(54);
    set_config(16'($urandom_range(0, 18000)), 16'($urandom_range(0, 18000)),
               16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
    sink_mode = SINK_CHOKED;
    gap_max = 8;
    run_sessions(54);
    set_config('1, '1, '1, '1);
    sink_mode = SINK_OPEN;
    gap_max = 0;
    run_sessions(54);
    set_config('0, '0, ENTER_DWELL_RST, LEAVE_DWELL_RST);
    sink_mode = SINK_RANDOM;
    gap_max = 2;
    run_sessions(54);
  endtask

  initial begin
    rst_ni             = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.op         = OP_OBSERVE;
    item_ch.stamp_ms   = '0;
    item_ch.face_x     = '0;
    item_ch.face_y     = '0;
    item_ch.face_w     = '0;
    item_ch.face_h     = '0;
    item_ch.yaw_cdeg   = '0;
    item_ch.pitch_cdeg = '0;
    item_ch.roll_cdeg  = '0;
    item_ch.certainty  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_YAW_LIMIT;
    cfg_ch.data        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_sessions();

    settle();
    if (err_count == 0) begin
      $display("tb_gaze_presence_dwell_tracker: clean");
    end else begin
      $display("tb_gaze_presence_dwell_tracker: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("tb_gaze_presence_dwell_tracker: errors");
    $finish;
  end

endmodule
